>>> sv/dmrc_pkg.sv
// Package for the direct-mapped read cache: field widths, operation codes,
// timing constants and parameter defaults. Depends on nothing.
`default_nettype none

package dmrc_pkg;

   localparam int ADDR_W  = 12;
   localparam int DATA_W  = 8;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [TIME_W-1:0] ACCESS_TIME  = 32'd1;
   localparam logic [TIME_W-1:0] FILL_PENALTY = 32'd10;

   localparam int LINES_DEF         = 8;
   localparam int LINE_BYTES_DEF    = 16;
   localparam int BACKING_BYTES_DEF = 4096;

endpackage

`default_nettype wire

>>> sv/dmrc_if.sv
// Valid/ready channel interfaces for the request and response words of the
// direct-mapped read cache. Depends on dmrc_pkg.
`default_nettype none

interface dmrc_req_if;
   import dmrc_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, operation, address, write_data, input ready);
   modport sink   (input valid, operation, address, write_data, output ready);
endinterface

interface dmrc_rsp_if;
   import dmrc_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [DATA_W-1:0]  read_data;
   logic [TIME_W-1:0]  elapsed_time;
   logic [COUNT_W-1:0] hit_total;
   logic [COUNT_W-1:0] miss_total;

   modport source (output valid, hit, read_data, elapsed_time, hit_total, miss_total,
                   input ready);
   modport sink   (input valid, hit, read_data, elapsed_time, hit_total, miss_total,
                   output ready);
endinterface

`default_nettype wire

>>> sv/direct_mapped_read_cache.sv
// Top level of the direct-mapped read cache: backing store memory, line memory,
// miss sequencer and response register. Depends on dmrc_pkg and dmrc_if.
`default_nettype none

// Read-only direct-mapped cache with LINES lines of LINE_BYTES bytes in front of a
// BACKING_BYTES byte backing store; all three parameters must be powers of two.
// One request word is handled at a time. A backing write goes straight to the done
// state; a read that hits passes the lookup state (line memory read and tag compare),
// and a read that misses passes the lookup and fill states, the line being filled one
// byte per cycle through the single read port of the backing memory. The response
// register lets the next request word be taken while the previous response word
// still waits. Line valid bits clear at reset, so no clearing pass is needed; the
// backing store holds no defined value until written.
module direct_mapped_read_cache #(
   parameter int LINES         = dmrc_pkg::LINES_DEF,
   parameter int LINE_BYTES    = dmrc_pkg::LINE_BYTES_DEF,
   parameter int BACKING_BYTES = dmrc_pkg::BACKING_BYTES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dmrc_req_if.sink    req_if,
   dmrc_rsp_if.source  rsp_if
);
   import dmrc_pkg::*;

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int IDX_W  = $clog2(LINES);
   localparam int BK_W   = $clog2(BACKING_BYTES);
   localparam int TAG_W  = (ADDR_W > OFF_W + IDX_W) ? ADDR_W - OFF_W - IDX_W : 1;
   localparam int EXT_W  = ADDR_W + IDX_W + BK_W;
   localparam int BYTES_W = LINE_BYTES * DATA_W;
   localparam int LINE_W = TAG_W + BYTES_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_FILL   = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   localparam logic [OFF_W-1:0] LAST_BYTE = OFF_W'(LINE_BYTES - 1);
   localparam logic [TIME_W-1:0] MISS_TIME = ACCESS_TIME + FILL_PENALTY;

   logic [1:0]         state_ff, state_in;
   logic               op_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [OFF_W-1:0]   fill_cnt_ff, fill_cnt_in;
   logic [BYTES_W-1:0] fill_buf_ff;
   logic [DATA_W-1:0]  byte_ff, byte_in;
   logic               pend_hit_ff, pend_hit_in;
   logic [LINES-1:0]   line_valid_ff;

   logic [TIME_W-1:0]  time_ff, time_in;
   logic [COUNT_W-1:0] hits_ff, hits_in;
   logic [COUNT_W-1:0] misses_ff, misses_in;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic [COUNT_W-1:0] rsp_hits_ff;
   logic [COUNT_W-1:0] rsp_misses_ff;

   logic [DATA_W-1:0]  backing_mem [BACKING_BYTES];
   logic [DATA_W-1:0]  backing_q;
   logic [LINE_W-1:0]  line_mem [LINES];
   logic [LINE_W-1:0]  line_q;

   logic               req_accept;
   logic               slot_free;
   logic               load_rsp;
   logic               fill_last;
   logic               back_rd_en;
   logic [OFF_W-1:0]   back_rd_off;
   logic [BK_W-1:0]    back_rd_addr;
   logic [BK_W-1:0]    back_wr_addr;
   logic [EXT_W-1:0]   req_ext;
   logic [EXT_W-1:0]   cur_ext;
   logic [EXT_W-1:0]   src_ext;
   logic [IDX_W-1:0]   req_line;
   logic [IDX_W-1:0]   cur_line;
   logic [TAG_W-1:0]   cur_tag;
   logic [OFF_W-1:0]   cur_off;
   logic               lookup_hit;
   logic [BYTES_W-1:0] fill_buf_in;
   logic               line_wr_en;

   assign req_ext  = EXT_W'(req_if.address);
   assign cur_ext  = EXT_W'(addr_ff);
   assign req_line = req_ext[OFF_W +: IDX_W];
   assign cur_line = cur_ext[OFF_W +: IDX_W];
   assign cur_tag  = cur_ext[OFF_W + IDX_W +: TAG_W];
   assign cur_off  = addr_ff[OFF_W-1:0];

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign load_rsp     = (state_ff == S_DONE) && slot_free;
   assign fill_last    = (state_ff == S_FILL) && (fill_cnt_ff == LAST_BYTE);

   assign lookup_hit = line_valid_ff[cur_line] && (line_q[BYTES_W +: TAG_W] == cur_tag);

   assign back_wr_addr = req_ext[BK_W-1:0];
   assign back_rd_off  = (state_ff == S_LOOKUP) ? '0 : fill_cnt_ff + 1'b1;
   assign src_ext      = EXT_W'({addr_ff[ADDR_W-1:OFF_W], back_rd_off});
   assign back_rd_addr = src_ext[BK_W-1:0];
   assign back_rd_en   = ((state_ff == S_LOOKUP) && !lookup_hit) ||
                         ((state_ff == S_FILL) && !fill_last);

   assign fill_buf_in = {backing_q, fill_buf_ff[BYTES_W-1:DATA_W]};
   assign line_wr_en  = fill_last;

   always_ff @(posedge clock) begin
      if (req_accept && (req_if.operation == OP_WRITE)) begin
         backing_mem[back_wr_addr] <= req_if.write_data;
      end
      if (back_rd_en) begin
         backing_q <= backing_mem[back_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (line_wr_en) begin
         line_mem[cur_line] <= {cur_tag, fill_buf_in};
      end
      if (req_accept) begin
         line_q <= line_mem[req_line];
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_cnt_in = fill_cnt_ff;
      byte_in     = byte_ff;
      pend_hit_in = pend_hit_ff;
      time_in     = time_ff;
      hits_in     = hits_ff;
      misses_in   = misses_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pend_hit_in = 1'b0;
               byte_in     = '0;
               state_in    = (req_if.operation == OP_READ) ? S_LOOKUP : S_DONE;
            end
         end
         S_LOOKUP: begin
            fill_cnt_in = '0;
            if (lookup_hit) begin
               pend_hit_in = 1'b1;
               byte_in     = line_q[DATA_W*cur_off +: DATA_W];
               state_in    = S_DONE;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == cur_off) begin
               byte_in = backing_q;
            end
            if (fill_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
               if (op_ff == OP_READ) begin
                  time_in = time_ff + (pend_hit_ff ? ACCESS_TIME : MISS_TIME);
                  if (pend_hit_ff) begin
                     hits_in = hits_ff + 1'b1;
                  end else begin
                     misses_in = misses_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         line_valid_ff <= '0;
         time_ff       <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         time_ff   <= time_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         if (fill_last) begin
            line_valid_ff[cur_line] <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_cnt_ff <= fill_cnt_in;
      byte_ff     <= byte_in;
      pend_hit_ff <= pend_hit_in;
      if (state_ff == S_FILL) begin
         fill_buf_ff <= fill_buf_in;
      end
      if (req_accept) begin
         op_ff   <= req_if.operation;
         addr_ff <= req_if.address;
      end
      if (load_rsp) begin
         rsp_hit_ff    <= pend_hit_ff;
         rsp_data_ff   <= byte_ff;
         rsp_time_ff   <= time_in;
         rsp_hits_ff   <= hits_in;
         rsp_misses_ff <= misses_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.read_data    = rsp_data_ff;
   assign rsp_if.elapsed_time = rsp_time_ff;
   assign rsp_if.hit_total    = rsp_hits_ff;
   assign rsp_if.miss_total   = rsp_misses_ff;

   // A hit response word advances the hit count only.
   assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (op_ff == OP_READ) && pend_hit_ff) |=>
         (hits_ff == $past(hits_ff) + 1'b1) && (misses_ff == $past(misses_ff)))
      else $error("hit response did not advance the hit count alone");

   // The line just filled is valid afterwards.
   assert property (@(posedge clock) disable iff (reset)
      fill_last |=> line_valid_ff[$past(cur_line)])
      else $error("filled line not marked valid");

   // A backing write goes straight to the response stage and leaves the time alone.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.operation == OP_WRITE)) |=>
         (state_ff == S_DONE) && $stable(time_ff))
      else $error("backing write took the wrong path");

endmodule

`default_nettype wire
